// ===== design/tlac_pkg.sv =====
`timescale 1ns / 1ps

package tlac_pkg;

  localparam int unsigned TravelWidth  = 16;
  localparam int unsigned ElapsedWidth = 17;
  localparam logic [ElapsedWidth-1:0] ElapsedMax = {ElapsedWidth{1'b1}};

  // Input word opcode.
  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TravelWidth-1:0] TravelReset = TravelWidth'(10);

  // Position codes as reported on the result word.
  typedef enum logic [2:0] {
    POS_OFF        = 3'd0,
    POS_EXTENDED   = 3'd1,
    POS_EXTENDING  = 3'd2,
    POS_RETRACTING = 3'd3,
    POS_RETRACTED  = 3'd4
  } pos_t;

  typedef struct packed {
    logic       drive_extend;
    logic       drive_retract;
    logic [2:0] position_state;
    logic       position_changed;
  } result_t;

endpackage

// ===== design/tlac_if.sv =====
`timescale 1ns / 1ps

interface tlac_in_if;
  logic valid;
  logic ready;
  logic op;
  logic command_extend;

  modport source (output valid, output op, output command_extend, input ready);
  modport sink (input valid, input op, input command_extend, output ready);
endinterface

interface tlac_out_if;
  logic       valid;
  logic       ready;
  logic       drive_extend;
  logic       drive_retract;
  logic [2:0] position_state;
  logic       position_changed;

  modport source (output valid, output drive_extend, output drive_retract,
                  output position_state, output position_changed, input ready);
  modport sink (input valid, input drive_extend, input drive_retract,
                input position_state, input position_changed, output ready);
endinterface

interface tlac_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/timed_linear_actuator_controller_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_ch     sink       op, command_extend
// out_ch    source     drive_extend, drive_retract, position_state, position_changed
// cfg_ch    sink       data (travel_seconds)
//
// The result word of each input word is registered and appears on the cycle
// after acceptance. One word can be accepted every cycle unless in_ch stalls.
// The only storage between the sides is the result register: in_ch stalls only
// while a result is held and out_ch.ready is low.
// Reset (rst_n low, synchronous) sets position off, timer stopped, travel 10.
// cfg_ch is always ready; writes take effect for the next accepted word.

module timed_linear_actuator_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  tlac_in_if.sink     in_ch,
  tlac_out_if.source  out_ch,
  tlac_cfg_if.sink    cfg_ch
);

  logic              can_load;
  logic              accept;
  tlac_pkg::result_t result;

  assign in_ch.ready  = can_load;
  assign accept       = in_ch.valid && can_load;
  assign cfg_ch.ready = 1'b1;

  tlac_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .op             (in_ch.op),
    .command_extend (in_ch.command_extend),
    .cfg_we         (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .result         (result)
  );

  tlac_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

// ===== design/tlac_core.sv =====
`timescale 1ns / 1ps

module tlac_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                op,
  input  logic                                command_extend,
  input  logic                                cfg_we,
  input  logic [tlac_pkg::TravelWidth-1:0]    cfg_data,
  output tlac_pkg::result_t                   result
);

  logic [tlac_pkg::TravelWidth-1:0]  travel_r;
  tlac_pkg::pos_t                    pos_r, pos_nxt;
  tlac_pkg::pos_t                    goal_r, goal_nxt;
  logic [tlac_pkg::ElapsedWidth-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic                              running_r, running_nxt;
  logic                              go;

  always_comb begin
    unique case (pos_r)
      tlac_pkg::POS_EXTENDED,
      tlac_pkg::POS_EXTENDING:  go = !command_extend;
      tlac_pkg::POS_RETRACTED,
      tlac_pkg::POS_RETRACTING: go = command_extend;
      default:                  go = 1'b1;
    endcase
  end

  assign elapsed_inc = (elapsed_r == tlac_pkg::ElapsedMax) ? elapsed_r
                                                           : elapsed_r + 1'b1;

  always_comb begin
    pos_nxt     = pos_r;
    goal_nxt    = goal_r;
    elapsed_nxt = elapsed_r;
    running_nxt = running_r;
    if (accept) begin
      if (op == tlac_pkg::OP_MOVE) begin
        if (go) begin
          goal_nxt    = command_extend ? tlac_pkg::POS_EXTENDED : tlac_pkg::POS_RETRACTED;
          pos_nxt     = command_extend ? tlac_pkg::POS_EXTENDING : tlac_pkg::POS_RETRACTING;
          elapsed_nxt = '0;
          running_nxt = 1'b1;
        end
      end else if (running_r) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > {1'b0, travel_r}) begin
          running_nxt = 1'b0;
          pos_nxt     = goal_r;
        end
      end
    end
  end

  // The last reported position always equals the held position, so a change
  // is seen by comparing against the current state.
  always_comb begin
    result.drive_extend     = (pos_nxt == tlac_pkg::POS_EXTENDING);
    result.drive_retract    = (pos_nxt == tlac_pkg::POS_RETRACTING);
    result.position_state   = pos_nxt;
    result.position_changed = (pos_nxt != pos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_r  <= tlac_pkg::TravelReset;
      pos_r     <= tlac_pkg::POS_OFF;
      goal_r    <= tlac_pkg::POS_OFF;
      elapsed_r <= '0;
      running_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        travel_r <= cfg_data;
      end
      pos_r     <= pos_nxt;
      goal_r    <= goal_nxt;
      elapsed_r <= elapsed_nxt;
      running_r <= running_nxt;
    end
  end

  a_idle_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (pos_r != tlac_pkg::POS_EXTENDING && pos_r != tlac_pkg::POS_RETRACTING))
    else $error("actuator in motion with timer stopped");

  a_idle_tick_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == tlac_pkg::OP_TICK && !running_r) |=> $stable(pos_r))
    else $error("tick while idle changed the position");

  a_start_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == tlac_pkg::OP_MOVE && go) |=> (running_r && elapsed_r == '0))
    else $error("move start did not restart the timer");

  a_running_has_goal: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (goal_r == tlac_pkg::POS_EXTENDED || goal_r == tlac_pkg::POS_RETRACTED))
    else $error("timer running without a goal");

endmodule

// ===== design/tlac_out_reg.sv =====
`timescale 1ns / 1ps

module tlac_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tlac_pkg::result_t result,
  output logic              can_load,
  tlac_out_if.source        out_ch
);

  logic              valid_r;
  tlac_pkg::result_t data_r;

  // A new word may enter whenever the register is empty or the held one leaves in the same cycle.
  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.drive_extend     = data_r.drive_extend;
  assign out_ch.drive_retract    = data_r.drive_retract;
  assign out_ch.position_state   = data_r.position_state;
  assign out_ch.position_changed = data_r.position_changed;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ch.ready) |=> (valid_r && $stable(data_r)))
    else $error("stalled result word was lost or changed");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("result loaded while output register blocked");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

endmodule

// ===== sim/tlac_checker.sv =====
`timescale 1ns / 1ps

module tlac_checker (
  input  logic clk,
  input  logic rst_n,
  tlac_in_if   in_ch,
  tlac_out_if  out_ch,
  tlac_cfg_if  cfg_ch,
  output int   fail_count,
  output int   results_owed
);

  tlac_pkg::pos_t                              position;
  tlac_pkg::pos_t                              goal_position;
  tlac_pkg::pos_t                              shown_position;
  logic [tlac_pkg::ElapsedWidth-1:0]           elapsed_ticks;
  logic                                        timer_on;
  logic [tlac_pkg::TravelWidth-1:0]            travel_limit;
  tlac_pkg::result_t                           status_due[$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Applies one input word to the actuator state and returns the status word it causes.
  task automatic step_actuator(input logic op, input logic extend_cmd,
                               output tlac_pkg::result_t word);
    logic go;
    go = 1'b0;
    if (op == tlac_pkg::OP_MOVE) begin
      case (position)
        tlac_pkg::POS_EXTENDED,
        tlac_pkg::POS_EXTENDING:  go = !extend_cmd;
        tlac_pkg::POS_RETRACTED,
        tlac_pkg::POS_RETRACTING: go = extend_cmd;
        default:                  go = 1'b1;
      endcase
      if (go) begin
        if (extend_cmd) begin
          goal_position = tlac_pkg::POS_EXTENDED;
          position      = tlac_pkg::POS_EXTENDING;
        end else begin
          goal_position = tlac_pkg::POS_RETRACTED;
          position      = tlac_pkg::POS_RETRACTING;
        end
        elapsed_ticks = '0;
        timer_on      = 1'b1;
      end
    end else if (timer_on) begin
      if (elapsed_ticks != tlac_pkg::ElapsedMax) elapsed_ticks = elapsed_ticks + 1'b1;
      if (elapsed_ticks > {1'b0, travel_limit}) begin
        timer_on = 1'b0;
        position = goal_position;
      end
    end
    word.drive_extend     = (position == tlac_pkg::POS_EXTENDING);
    word.drive_retract    = (position == tlac_pkg::POS_RETRACTING);
    word.position_state   = position;
    word.position_changed = (position != shown_position);
    shown_position        = position;
  endtask

  always @(posedge clk) begin
    tlac_pkg::result_t seen;
    tlac_pkg::result_t want;
    if (!rst_n) begin
      position       = tlac_pkg::POS_OFF;
      goal_position  = tlac_pkg::POS_OFF;
      shown_position = tlac_pkg::POS_OFF;
      elapsed_ticks  = '0;
      timer_on       = 1'b0;
      travel_limit   = tlac_pkg::TravelReset;
      status_due.delete();
    end else begin
      // A result word always belongs to an input word accepted on an earlier edge.
      if (out_ch.valid && out_ch.ready) begin
        seen.drive_extend     = out_ch.drive_extend;
        seen.drive_retract    = out_ch.drive_retract;
        seen.position_state   = out_ch.position_state;
        seen.position_changed = out_ch.position_changed;
        if (status_due.size() == 0) begin
          flag_mismatch($sformatf("result word %b with none outstanding", seen));
        end else begin
          want = status_due.pop_front();
          if (seen.drive_extend !== want.drive_extend)
            flag_mismatch($sformatf("drive_extend %b, want %b",
                                    seen.drive_extend, want.drive_extend));
          if (seen.drive_retract !== want.drive_retract)
            flag_mismatch($sformatf("drive_retract %b, want %b",
                                    seen.drive_retract, want.drive_retract));
          if (seen.position_state !== want.position_state)
            flag_mismatch($sformatf("position_state %0d, want %0d",
                                    seen.position_state, want.position_state));
          if (seen.position_changed !== want.position_changed)
            flag_mismatch($sformatf("position_changed %b, want %b",
                                    seen.position_changed, want.position_changed));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        step_actuator(in_ch.op, in_ch.command_extend, want);
        status_due.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) travel_limit = cfg_ch.data;
    end
    results_owed = status_due.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int IdlePct    = 11;
  localparam int IdleLimit  = 2000;
  localparam int TravelBits = tlac_pkg::TravelWidth;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;
  int   fail_count;
  int   results_owed;
  int   idle_cycles;
  int   travel_now = 10;

  tlac_in_if  in_ch();
  tlac_out_if out_ch();
  tlac_cfg_if cfg_ch();

  timed_linear_actuator_controller_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tlac_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // Presents one word from a falling edge and returns at the falling edge after it
  // is taken, leaving valid high so that back-to-back words need no extra step.
  task automatic send_word(input logic op, input logic extend);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid          <= 1'b0;
      in_ch.op             <= 1'($urandom);
      in_ch.command_extend <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.command_extend <= extend;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_word(tlac_pkg::OP_TICK, 1'($urandom));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_travel(input logic [tlac_pkg::TravelWidth-1:0] value);
    drain_results();
    repeat (2) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    travel_now = int'(value);
  endtask

  // Mostly ticks, with commands spaced so that moves often run to completion.
  task automatic run_random(input int count);
    int span;
    span = travel_now / 2 + 2;
    repeat (count) begin
      if ($urandom_range(0, span) == 0) send_word(tlac_pkg::OP_MOVE, 1'($urandom));
      else send_word(tlac_pkg::OP_TICK, 1'($urandom));
    end
  endtask

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid          = 1'b0;
    in_ch.op             = tlac_pkg::OP_MOVE;
    in_ch.command_extend = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sequence on the reset travel time of 10 ticks.
    send_word(tlac_pkg::OP_TICK, 1'b1);
    send_word(tlac_pkg::OP_TICK, 1'b0);
    send_word(tlac_pkg::OP_MOVE, 1'b0);
    send_word(tlac_pkg::OP_MOVE, 1'b0);
    send_ticks(1);
    send_word(tlac_pkg::OP_MOVE, 1'b1);
    send_word(tlac_pkg::OP_MOVE, 1'b1);
    send_ticks(2);
    send_word(tlac_pkg::OP_MOVE, 1'b0);
    send_ticks(11);
    send_word(tlac_pkg::OP_MOVE, 1'b0);
    send_ticks(1);
    send_word(tlac_pkg::OP_MOVE, 1'b1);

    // Zero travel: the move in progress ends on the next tick.
    write_travel(16'd0);
    send_ticks(1);
    send_word(tlac_pkg::OP_MOVE, 1'b0);
    send_ticks(1);
    run_random(150);

    write_travel(16'd1);
    run_random(150);

    // Longest travel: moves and reversals that stay under way.
    write_travel(16'hFFFF);
    send_word(tlac_pkg::OP_MOVE, 1'b0);
    send_word(tlac_pkg::OP_MOVE, 1'b1);
    send_ticks(30);
    send_word(tlac_pkg::OP_MOVE, 1'b0);
    send_ticks(5);
    send_word(tlac_pkg::OP_MOVE, 1'b1);
    send_ticks(3);

    for (int phase = 0; phase < 6; phase++) begin
      write_travel(TravelBits'($urandom_range(2, 24)));
      calm <= (phase == 2);
      run_random(65);
      if (phase == 3) drain_results();
      run_random(65);
    end
    calm <= 1'b0;

    drain_results();
    repeat (3) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tlac_pkg.sv
design/tlac_if.sv
design/tlac_core.sv
design/tlac_out_reg.sv
design/timed_linear_actuator_controller_unit.sv
sim/tlac_checker.sv
sim/tb.sv
